@@ design/fdm_pkg.sv @@
// Shared types and constants for the FAT directory entry matcher.
// No dependencies; imported by every module of the block.
package fdm_pkg;

  localparam int unsigned ENTRY_LAST = 31;
  localparam int unsigned NAME_BYTES = 11;
  localparam int unsigned ATTR_POS   = 11;

  localparam logic [7:0] MARK_END      = 8'h00;
  localparam logic [7:0] MARK_DELETED  = 8'hE5;
  localparam logic [7:0] ATTR_LONGNAME = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME   = 8'h08;

  localparam logic [63:0] NAME_BASE_RESET = 64'h2020_2020_2020_2020;
  localparam logic [23:0] NAME_EXT_RESET  = 24'h20_2020;

  localparam logic CFG_NAME_BASE = 1'b0;
  localparam logic CFG_NAME_EXT  = 1'b1;

  localparam int unsigned RES_DATA_W = 72;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_CORRUPT   = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  attributes;
    logic [31:0] file_size;
    logic [31:0] start_cluster;
  } res_t;

endpackage

@@ design/fat_directory_entry_matcher_top.sv @@
// Top level of the FAT short-name directory matcher: input register and wiring.
// Depends on fdm_pkg, fdm_entry_scan and fdm_result_fifo.
//
//  channel  direction  payload
//  s_*      in         tdata[7:0] dir_byte, tuser[0] restart
//  m_*      out        tdata {attributes, file_size, start_cluster}, tuser status
//  cfg_*    in         cfg_index selects register, cfg_data holds the value
//
// One directory byte is taken every cycle while the buffer has space; a result
// for a byte passes through the input register and then the two-entry buffer.
// Input stalls only when the result buffer is full. Reset is synchronous and
// clears the search state and sets the name registers to all spaces.
module fat_directory_entry_matcher_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] dir_byte
  input  logic                           s_tuser,   // [0] restart
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fdm_pkg::RES_DATA_W-1:0] m_tdata,   // [31:0] start_cluster,
                                                    // [63:32] file_size,
                                                    // [71:64] attributes
  output logic [1:0]                     m_tuser,   // [1:0] status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [63:0]                    cfg_data
);
  import fdm_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;
  logic       advance;
  logic       space;
  logic       res_valid;
  res_t       res;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && space;
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte    <= s_tdata;
      in_restart <= s_tuser;
    end
  end

  fdm_entry_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (advance),
    .dir_byte   (in_byte),
    .restart    (in_restart),
    .res_valid  (res_valid),
    .res        (res)
  );

  fdm_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_data (res),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ design/fdm_entry_scan.sv @@
// Directory entry scanner: search state, name registers and result decision.
// Depends on fdm_pkg; one accepted byte is handled per cycle.
module fdm_entry_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [63:0]     cfg_data,
  input  logic            item_valid,
  input  logic [7:0]      dir_byte,
  input  logic            restart,
  output logic            res_valid,
  output fdm_pkg::res_t   res
);
  import fdm_pkg::*;

  logic [63:0] name_base;
  logic [23:0] name_ext;
  logic [4:0]  position;
  logic        name_equal;
  logic        skip_entry;
  logic        search_done;
  logic [7:0]  attr_hold;
  logic [31:0] cluster_hold;
  logic [31:0] size_hold;

  logic [4:0]  position_next;
  logic        name_equal_next;
  logic        skip_entry_next;
  logic        search_done_next;
  logic [7:0]  attr_hold_next;
  logic [31:0] cluster_hold_next;
  logic [31:0] size_hold_next;

  logic [4:0]  pos_e;
  logic        eq_e;
  logic        skip_e;
  logic        done_e;
  logic [7:0]  wanted;

  always_comb begin
    pos_e  = restart ? 5'd0 : position;
    eq_e   = restart ? 1'b1 : name_equal;
    skip_e = restart ? 1'b0 : skip_entry;
    done_e = restart ? 1'b0 : search_done;

    if (pos_e[4:3] == 2'b00) begin
      wanted = name_base[{~pos_e[2:0], 3'b000} +: 8];
    end else begin
      case (pos_e[1:0])
        2'd0:    wanted = name_ext[23:16];
        2'd1:    wanted = name_ext[15:8];
        default: wanted = name_ext[7:0];
      endcase
    end

    position_next     = pos_e;
    name_equal_next   = eq_e;
    skip_entry_next   = skip_e;
    search_done_next  = done_e;
    attr_hold_next    = attr_hold;
    cluster_hold_next = cluster_hold;
    size_hold_next    = size_hold;
    res_valid         = 1'b0;
    res               = '0;
    res.status        = ST_FOUND;

    if (!done_e) begin
      if (pos_e == 5'd0 && dir_byte == MARK_END) begin
        search_done_next = 1'b1;
        res_valid        = 1'b1;
        res.status       = ST_NOT_FOUND;
      end else begin
        if (pos_e == 5'd0 && dir_byte == MARK_DELETED) begin
          skip_entry_next = 1'b1;
        end
        if (pos_e < 5'(NAME_BYTES)) begin
          if (dir_byte != wanted) begin
            name_equal_next = 1'b0;
          end
        end else if (pos_e == 5'(ATTR_POS)) begin
          attr_hold_next = dir_byte;
          if (dir_byte == ATTR_LONGNAME || (dir_byte & ATTR_VOLUME) != 8'h00) begin
            skip_entry_next = 1'b1;
          end
        end else if (pos_e == 5'd20) begin
          cluster_hold_next[23:16] = dir_byte;
        end else if (pos_e == 5'd21) begin
          cluster_hold_next[31:24] = dir_byte;
        end else if (pos_e == 5'd26) begin
          cluster_hold_next[7:0] = dir_byte;
        end else if (pos_e == 5'd27) begin
          cluster_hold_next[15:8] = dir_byte;
        end else if (pos_e >= 5'd28) begin
          size_hold_next[{pos_e[1:0], 3'b000} +: 8] = dir_byte;
        end

        if (pos_e == 5'(ENTRY_LAST)) begin
          position_next   = 5'd0;
          name_equal_next = 1'b1;
          skip_entry_next = 1'b0;
          if (eq_e && !skip_e) begin
            search_done_next  = 1'b1;
            res_valid         = 1'b1;
            res.start_cluster = cluster_hold_next;
            res.file_size     = size_hold_next;
            res.attributes    = attr_hold_next;
            if (cluster_hold_next < 32'd2 && size_hold_next != 32'd0) begin
              res.status = ST_CORRUPT;
            end else begin
              res.status = ST_FOUND;
            end
          end
        end else begin
          position_next = pos_e + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_base    <= NAME_BASE_RESET;
      name_ext     <= NAME_EXT_RESET;
      position     <= 5'd0;
      name_equal   <= 1'b1;
      skip_entry   <= 1'b0;
      search_done  <= 1'b0;
      attr_hold    <= 8'h00;
      cluster_hold <= 32'd0;
      size_hold    <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NAME_BASE: name_base <= cfg_data;
          CFG_NAME_EXT:  name_ext  <= cfg_data[23:0];
          default:       name_base <= name_base;
        endcase
      end
      if (item_valid) begin
        position     <= position_next;
        name_equal   <= name_equal_next;
        skip_entry   <= skip_entry_next;
        search_done  <= search_done_next;
        attr_hold    <= attr_hold_next;
        cluster_hold <= cluster_hold_next;
        size_hold    <= size_hold_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_result_ends_search: assert property (@(posedge clk) disable iff (rst)
    (item_valid && res_valid) |=> search_done)
    else $error("search not marked done after a result");

  a_quiet_when_done: assert property (@(posedge clk) disable iff (rst)
    (search_done && !restart) |-> !res_valid)
    else $error("result produced after the search had ended");

  a_match_at_entry_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_NOT_FOUND) |-> (pos_e == 5'(ENTRY_LAST)))
    else $error("match reported before the last byte of an entry");
`endif

endmodule

@@ design/fdm_result_fifo.sv @@
// Two-entry result buffer between the scanner and the master stream side.
// Depends on fdm_pkg for the result record.
module fdm_result_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  fdm_pkg::res_t                       push_data,
  output logic                                space,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fdm_pkg::RES_DATA_W-1:0]      m_tdata,
  output logic [1:0]                          m_tuser
);
  import fdm_pkg::*;

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = count != 2'd0;
  assign space    = count != 2'd2;
  assign m_tdata  = {slots[rd_ptr].attributes, slots[rd_ptr].file_size,
                     slots[rd_ptr].start_cluster};
  assign m_tuser  = slots[rd_ptr].status;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2))
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd0) |=> m_tvalid)
    else $error("pushed result not offered on the output");
`endif

endmodule
